@@ rtl/krt_pkg.sv @@
// krt_pkg: shared types and constants of the keyed record table
// item structs, operation and status codes, classified command format
// no dependencies
package krt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_UPDATE = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  localparam logic signed [31:0] QTY_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] QTY_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] part_key;
    logic signed [31:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] found_key;
    logic signed [31:0] found_quantity;
    logic               last_of_run;
  } out_item_t;

  // command as held between the front queue and the engine
  typedef struct packed {
    op_e                op;
    logic signed [31:0] key;
    logic signed [31:0] amount;
  } cmd_t;

  // handshake between front queue and engine
  typedef struct packed {
    logic valid;
  } cmd_ctl_t;

endpackage

@@ rtl/keyed_record_table.sv @@
// keyed_record_table: top level of the keyed record table
// joins the front command queue and the back engine with record memories
// depends on krt_pkg, krt_front, krt_engine
//
//   channel   | ports                          | beat taken when
//   ----------+--------------------------------+-------------------------
//   request   | push_i, full_o, in_item_i      | push_i high, full_o low
//   result    | pop_i, empty_o, out_item_o     | pop_i high, empty_o low
//
// a two-deep command queue takes requests while the engine is busy
// insert into a full table, and any request on an empty table, are answered from idle without a scan
// search, update and insert scan the record memory record by record (read then
// compare); list reads each record in turn and emits it
// the engine takes a new command only when the result register is free or
// being popped; a list stalls on each record until the previous one is taken
// reset clears the record count and all valid flags; the memories need no clearing
module keyed_record_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request side
  input  logic               push_i,
  output logic               full_o,
  input  krt_pkg::in_item_t  in_item_i,
  // result side
  input  logic               pop_i,
  output logic               empty_o,
  output krt_pkg::out_item_t out_item_o
);

  krt_pkg::cmd_ctl_t cmd_ctl;
  krt_pkg::cmd_t     cmd;
  logic              cmd_pop;
  logic              res_valid;

  // front: decode and buffer requests
  krt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .in_item_i (in_item_i),
    .cmd_ctl_o (cmd_ctl),
    .cmd_o     (cmd),
    .cmd_pop_i (cmd_pop)
  );

  // back: table search, update, append and listing
  krt_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_ctl_i   (cmd_ctl),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_o       (out_item_o),
    .res_valid_o (res_valid),
    .res_pop_i   (pop_i)
  );

  // result register shows as a one-entry queue
  assign empty_o = !res_valid;

endmodule

@@ rtl/krt_front.sv @@
// krt_front: input side of the keyed record table
// accepts request beats, decodes the opcode and buffers two commands
// depends on krt_pkg
module krt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  krt_pkg::in_item_t in_item_i,
  output krt_pkg::cmd_ctl_t cmd_ctl_o,
  output krt_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  krt_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;
  logic          do_push;
  logic          do_pop;
  krt_pkg::cmd_t decoded;

  assign full_o  = (fill_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = cmd_pop_i && (fill_q != 2'd0);

  always_comb begin
    decoded.op     = krt_pkg::op_e'(in_item_i.opcode);
    decoded.key    = in_item_i.part_key;
    decoded.amount = in_item_i.amount;
  end

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= decoded;
    end
  end

  assign cmd_ctl_o.valid = (fill_q != 2'd0);
  assign cmd_o           = slot_q[rd_ptr_q];

endmodule

@@ rtl/krt_engine.sv @@
// krt_engine: back part of the keyed record table
// holds the record memories and count, scans entry by entry, drives the result register
// depends on krt_pkg
module krt_engine #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  krt_pkg::cmd_ctl_t  cmd_ctl_i,
  input  krt_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output krt_pkg::out_item_t res_o,
  output logic               res_valid_o,
  input  logic               res_pop_i
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_LIST = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  krt_pkg::cmd_t      cur_q, cur_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_vld_q;
  krt_pkg::out_item_t res_q;

  logic signed [31:0] key_mem [TABLE_DEPTH];
  logic signed [31:0] qty_mem [TABLE_DEPTH];
  logic signed [31:0] key_rd_q;
  logic signed [31:0] qty_rd_q;

  logic               key_we, qty_we;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [31:0] wr_key, wr_qty;
  logic               emit;
  krt_pkg::out_item_t emit_item;
  logic               out_free;
  logic               is_last;
  logic               hit;
  logic signed [32:0] sum;
  logic signed [31:0] sat_sum;

  assign out_free = !out_vld_q || res_pop_i;
  assign is_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
  assign hit      = (key_rd_q == cur_q.key);

  // saturating add for update
  always_comb begin
    sum = {qty_rd_q[31], qty_rd_q} + {cur_q.amount[31], cur_q.amount};
    if (sum[32] != sum[31]) begin
      sat_sum = sum[32] ? krt_pkg::QTY_MIN : krt_pkg::QTY_MAX;
    end else begin
      sat_sum = sum[31:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    cmd_pop_o = 1'b0;
    key_we    = 1'b0;
    qty_we    = 1'b0;
    wr_addr   = idx_q;
    wr_key    = cur_q.key;
    wr_qty    = cur_q.amount;
    emit      = 1'b0;
    emit_item = '0;
    emit_item.last_of_run = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_ctl_i.valid && out_free) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          idx_d     = '0;
          emit_item.found_key = cmd_i.key;
          priority if (cmd_i.op == krt_pkg::OP_LIST && cnt_q == '0) begin
            emit                = 1'b1;
            emit_item.status    = krt_pkg::ST_EMPTY;
            emit_item.found_key = '0;
          end else if (cmd_i.op == krt_pkg::OP_LIST) begin
            state_d = S_READ;
          end else if (cmd_i.op == krt_pkg::OP_INSERT &&
                       cnt_q == CNT_W'(TABLE_DEPTH)) begin
            emit             = 1'b1;
            emit_item.status = krt_pkg::ST_FULL;
          end else if (cnt_q == '0) begin
            emit = 1'b1;
            if (cmd_i.op == krt_pkg::OP_INSERT) begin
              key_we  = 1'b1;
              qty_we  = 1'b1;
              wr_addr = cnt_q[IDX_W-1:0];
              wr_key  = cmd_i.key;
              wr_qty  = cmd_i.amount;
              cnt_d   = cnt_q + CNT_W'(1);
              emit_item.status         = krt_pkg::ST_OK;
              emit_item.found_quantity = cmd_i.amount;
            end else begin
              emit_item.status = krt_pkg::ST_NOT_FOUND;
            end
          end else begin
            state_d = S_READ;
          end
        end
      end

      S_READ: begin
        state_d = (cur_q.op == krt_pkg::OP_LIST) ? S_LIST : S_CMP;
      end

      S_CMP: begin
        emit_item.found_key = cur_q.key;
        if (hit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          unique case (cur_q.op)
            krt_pkg::OP_INSERT: begin
              emit_item.status         = krt_pkg::ST_DUPLICATE;
              emit_item.found_quantity = qty_rd_q;
            end
            krt_pkg::OP_UPDATE: begin
              qty_we                   = 1'b1;
              wr_qty                   = sat_sum;
              emit_item.status         = krt_pkg::ST_OK;
              emit_item.found_quantity = sat_sum;
            end
            default: begin
              emit_item.status         = krt_pkg::ST_OK;
              emit_item.found_quantity = qty_rd_q;
            end
          endcase
        end else if (is_last) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (cur_q.op == krt_pkg::OP_INSERT) begin
            // miss on a table with room: append
            key_we  = 1'b1;
            qty_we  = 1'b1;
            wr_addr = cnt_q[IDX_W-1:0];
            cnt_d   = cnt_q + CNT_W'(1);
            emit_item.status         = krt_pkg::ST_OK;
            emit_item.found_quantity = cur_q.amount;
          end else begin
            emit_item.status = krt_pkg::ST_NOT_FOUND;
          end
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_READ;
        end
      end

      S_LIST: begin
        if (out_free) begin
          emit                     = 1'b1;
          emit_item.status         = krt_pkg::ST_OK;
          emit_item.found_key      = key_rd_q;
          emit_item.found_quantity = qty_rd_q;
          emit_item.last_of_run    = is_last;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_READ;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (res_pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      res_q <= emit_item;
    end
  end

  // record memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (qty_we) begin
      qty_mem[wr_addr] <= wr_qty;
    end
    key_rd_q <= key_mem[idx_q];
    qty_rd_q <= qty_mem[idx_q];
  end

  assign res_o       = res_q;
  assign res_valid_o = out_vld_q;

endmodule

@@ tb/sv/testbench.sv @@
// testbench: self-checking bench for the keyed record table
// predicts every result from its own copy of the record table, checks each popped beat
// depends on krt_pkg and keyed_record_table
module testbench;

  localparam int TABLE_DEPTH = 64;
  // a search or update on a full table reads and compares every record
  localparam int SETTLE_CYCLES = 4 * TABLE_DEPTH + 20;
  // nothing accepted for this long means the block is hung
  localparam int HANG_LIMIT = 4000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push_i = 1'b0;
  logic               full_o;
  krt_pkg::in_item_t  in_item_i = '0;
  logic               pop_i = 1'b0;
  logic               empty_o;
  krt_pkg::out_item_t out_item_o;

  keyed_record_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .in_item_i (in_item_i),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .out_item_o(out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // record table as the block should hold it
  // ---------------------------------------------------------------------------
  logic signed [31:0] stored_keys [TABLE_DEPTH];
  logic signed [31:0] stored_qty  [TABLE_DEPTH];
  int                 stored_count = 0;

  // results still owed by the block, oldest first
  krt_pkg::out_item_t pending_results[$];

  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int status_seen[5] = '{default: 0};
  int saturations = 0;

  // idling knobs, in percent of cycles
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  function automatic int find_record(input logic signed [31:0] key);
    for (int i = 0; i < stored_count; i++) begin
      if (stored_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic krt_pkg::out_item_t make_result(input krt_pkg::status_e st,
                                                     input logic signed [31:0] key,
                                                     input logic signed [31:0] qty,
                                                     input logic last);
    krt_pkg::out_item_t r;
    r.status         = st;
    r.found_key      = key;
    r.found_quantity = qty;
    r.last_of_run    = last;
    return r;
  endfunction

  // apply one accepted request to the table copy and queue what it yields
  function automatic void apply_request(input krt_pkg::in_item_t req);
    int     slot;
    longint sum;
    slot = find_record(req.part_key);
    case (krt_pkg::op_e'(req.opcode))
      krt_pkg::OP_INSERT: begin
        // fullness wins over the duplicate test
        if (stored_count >= TABLE_DEPTH) begin
          pending_results.push_back(make_result(krt_pkg::ST_FULL, req.part_key, '0, 1'b1));
        end else if (slot >= 0) begin
          pending_results.push_back(make_result(krt_pkg::ST_DUPLICATE, req.part_key,
                                                stored_qty[slot], 1'b1));
        end else begin
          stored_keys[stored_count] = req.part_key;
          stored_qty[stored_count]  = req.amount;
          stored_count++;
          pending_results.push_back(make_result(krt_pkg::ST_OK, req.part_key, req.amount,
                                                1'b1));
        end
      end
      krt_pkg::OP_SEARCH: begin
        if (slot >= 0) begin
          pending_results.push_back(make_result(krt_pkg::ST_OK, req.part_key,
                                                stored_qty[slot], 1'b1));
        end else begin
          pending_results.push_back(make_result(krt_pkg::ST_NOT_FOUND, req.part_key, '0,
                                                1'b1));
        end
      end
      krt_pkg::OP_UPDATE: begin
        if (slot >= 0) begin
          // widen, add, then clamp to the signed 32-bit range
          sum = longint'(stored_qty[slot]) + longint'(req.amount);
          if (sum > longint'(krt_pkg::QTY_MAX)) begin
            sum = longint'(krt_pkg::QTY_MAX);
            saturations++;
          end else if (sum < longint'(krt_pkg::QTY_MIN)) begin
            sum = longint'(krt_pkg::QTY_MIN);
            saturations++;
          end
          stored_qty[slot] = sum[31:0];
          pending_results.push_back(make_result(krt_pkg::ST_OK, req.part_key,
                                                stored_qty[slot], 1'b1));
        end else begin
          pending_results.push_back(make_result(krt_pkg::ST_NOT_FOUND, req.part_key, '0,
                                                1'b1));
        end
      end
      default: begin
        // list: one beat per record in insertion order, or a lone empty beat
        if (stored_count == 0) begin
          pending_results.push_back(make_result(krt_pkg::ST_EMPTY, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < stored_count; i++) begin
            pending_results.push_back(make_result(krt_pkg::ST_OK, stored_keys[i],
                                                  stored_qty[i], i == stored_count - 1));
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // request side: one beat per call, push stays high into the next call
  // ---------------------------------------------------------------------------
  task automatic send_request(input krt_pkg::op_e op, input logic signed [31:0] key,
                              input logic signed [31:0] amount);
    krt_pkg::in_item_t req;
    req.opcode   = op;
    req.part_key = key;
    req.amount   = amount;
    // random idle cycles ahead of the beat
    while ($urandom_range(99) < sender_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_item_i <= req;
    // full_o read here is the value the edge saw
    do @(posedge clk_i); while (full_o);
    apply_request(req);
    requests_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random pop, checked against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pop_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    krt_pkg::out_item_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat status %0d key %0d",
                                  out_item_o.status, out_item_o.found_key));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status < 5) status_seen[want.status]++;
        if (out_item_o.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d (key %0d)",
                                    out_item_o.status, want.status, want.found_key));
        if (out_item_o.found_key !== want.found_key)
          report_mismatch($sformatf("found_key %0d, want %0d",
                                    out_item_o.found_key, want.found_key));
        if (out_item_o.found_quantity !== want.found_quantity)
          report_mismatch($sformatf("found_quantity %0d, want %0d (key %0d)",
                                    out_item_o.found_quantity, want.found_quantity,
                                    want.found_key));
        if (out_item_o.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %0b, want %0b (key %0d)",
                                    out_item_o.last_of_run, want.last_of_run,
                                    want.found_key));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles in a row with no beat on either side
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               HANG_LIMIT, pending_results.size());
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    // mostly keys already stored, so searches and updates land
    if (stored_count > 0 && roll < 60) return stored_keys[$urandom_range(stored_count - 1)];
    if (roll < 70) begin
      case ($urandom_range(3))
        0: return krt_pkg::QTY_MIN;
        1: return krt_pkg::QTY_MAX;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_amount();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return krt_pkg::QTY_MAX;
    if (roll < 20) return krt_pkg::QTY_MIN;
    if (roll < 40) return $signed(32'($urandom_range(200))) - 32'sd100;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty table, field extremes, every operation, saturation both ways
  task automatic test_directed();
    send_request(krt_pkg::OP_LIST,   32'sd0,  32'sd0);   // empty table
    send_request(krt_pkg::OP_SEARCH, 32'sd7,  32'sd0);   // missing key
    send_request(krt_pkg::OP_UPDATE, 32'sd7,  32'sd5);   // missing key
    send_request(krt_pkg::OP_INSERT, krt_pkg::QTY_MAX, krt_pkg::QTY_MAX);
    send_request(krt_pkg::OP_INSERT, krt_pkg::QTY_MIN, krt_pkg::QTY_MIN);
    send_request(krt_pkg::OP_INSERT, 32'sd0,  32'sd0);
    send_request(krt_pkg::OP_INSERT, -32'sd1, -32'sd1);
    // duplicate keeps stored quantity
    send_request(krt_pkg::OP_INSERT, krt_pkg::QTY_MAX, 32'sd3);
    // amount ignored
    send_request(krt_pkg::OP_SEARCH, krt_pkg::QTY_MIN, 32'sd99);
    send_request(krt_pkg::OP_UPDATE, krt_pkg::QTY_MAX, 32'sd1);   // clamps high
    send_request(krt_pkg::OP_UPDATE, krt_pkg::QTY_MIN, -32'sd1);  // clamps low
    send_request(krt_pkg::OP_UPDATE, 32'sd0,  krt_pkg::QTY_MAX);
    // lands on -1, no clamp
    send_request(krt_pkg::OP_UPDATE, 32'sd0,  krt_pkg::QTY_MIN);
    // clamps low by one
    send_request(krt_pkg::OP_UPDATE, -32'sd1, krt_pkg::QTY_MIN);
    send_request(krt_pkg::OP_UPDATE, krt_pkg::QTY_MAX, krt_pkg::QTY_MIN);
    send_request(krt_pkg::OP_SEARCH, 32'sd0,  32'sd0);
    send_request(krt_pkg::OP_SEARCH, 32'sd1,  32'sd0);   // missing with records present
    send_request(krt_pkg::OP_LIST,   32'sd5,  32'sd5);
  endtask

  // random mix of operations on a growing table
  task automatic test_mixed_traffic(input int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 35)      send_request(krt_pkg::OP_INSERT, pick_key(), pick_amount());
      else if (roll < 60) send_request(krt_pkg::OP_SEARCH, pick_key(), $urandom);
      else if (roll < 88) send_request(krt_pkg::OP_UPDATE, pick_key(), pick_amount());
      else                send_request(krt_pkg::OP_LIST,   $urandom, $urandom);
    end
  endtask

  // fill to capacity, then refused inserts and work on a full table
  task automatic test_full_table();
    logic signed [31:0] fresh;
    while (stored_count < TABLE_DEPTH)
      send_request(krt_pkg::OP_INSERT, $urandom, pick_amount());
    // a fresh key is refused as full
    do fresh = $urandom; while (find_record(fresh) >= 0);
    send_request(krt_pkg::OP_INSERT, fresh, 32'sd1);
    // a stored key is also refused as full, not as duplicate
    send_request(krt_pkg::OP_INSERT, stored_keys[TABLE_DEPTH - 1], 32'sd2);
    send_request(krt_pkg::OP_SEARCH, stored_keys[TABLE_DEPTH - 1], 32'sd0);
    send_request(krt_pkg::OP_UPDATE, stored_keys[0], pick_amount());
    send_request(krt_pkg::OP_SEARCH, fresh, 32'sd0);
    send_request(krt_pkg::OP_LIST, 32'sd0, 32'sd0);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0, 0);
    test_directed();
    test_mixed_traffic(14);
    set_idling(58, 0);
    test_mixed_traffic(14);
    set_idling(0, 58);
    test_mixed_traffic(14);
    set_idling(27, 27);
    test_mixed_traffic(14);
    // keep some stall while the table fills and the long list drains
    set_idling(27, 58);
    test_full_table();

    push_i <= 1'b0;
    // drain, then watch for stray beats
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("sent %0d requests, checked %0d result beats, %0d clamped updates",
             requests_sent, results_checked, saturations);
    $display("status mix ok/full/dup/missing/empty: %0d/%0d/%0d/%0d/%0d",
             status_seen[krt_pkg::ST_OK], status_seen[krt_pkg::ST_FULL],
             status_seen[krt_pkg::ST_DUPLICATE], status_seen[krt_pkg::ST_NOT_FOUND],
             status_seen[krt_pkg::ST_EMPTY]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, pending_results.size());
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
